[hdl/hlt_pkg.sv]
// Shared codes, command and status types for the heartbeat liveness table.
`default_nettype none
package hlt_pkg;

    // Input operation codes
    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_RECV   = 3'd2;
    localparam logic [2:0] OP_TICK   = 3'd3;
    localparam logic [2:0] OP_QUERY  = 3'd4;

    // Completion status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_EXISTS   = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_EVENT = 2'd0;
    localparam logic [1:0] KIND_SEND  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // Health states
    localparam logic [1:0] HEALTH_UNKNOWN = 2'd0;
    localparam logic [1:0] HEALTH_ALIVE   = 2'd1;
    localparam logic [1:0] HEALTH_SUSPECT = 2'd2;
    localparam logic [1:0] HEALTH_DEAD    = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_PERIOD  = 3'd0;
    localparam logic [2:0] CFG_TIMEOUT = 3'd1;
    localparam logic [2:0] CFG_AUTO    = 3'd2;
    localparam logic [2:0] CFG_TRACK   = 3'd3;
    localparam logic [2:0] CFG_OWN_ID  = 3'd4;

    localparam logic [7:0] INVALID_ID = 8'd255;

    // Which result record the output register is loaded with
    typedef enum logic [2:0] {
        RES_DONE,
        RES_QUERY,
        RES_EVENT,
        RES_SEND,
        RES_TICK
    } t_res;

    // Controller to datapath
    typedef struct packed {
        logic       in_ready;
        logic       idx_clr;
        logic       idx_inc;
        logic       rd_en;
        logic       rd_next;
        logic       wr_add;
        logic       wr_shift;
        logic       wr_recv;
        logic       wr_tick;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       chg_clr;
        logic       chg_inc;
        logic       div_start;
        logic       send_upd;
        logic       out_load;
        t_res       res;
        logic [2:0] status;
        logic       since_ones;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] op;
        logic       op_bad;
        logic       id_invalid;
        logic       idx_lt_cnt;
        logic       nxt_lt_cnt;
        logic       id_match;
        logic       full;
        logic       health_zero;
        logic       health_alive;
        logic       div_busy;
        logic       tick_changed;
        logic       send_due;
        logic       out_free;
    } t_stat;

endpackage
`default_nettype wire

[hdl/heartbeat_liveness_table.sv]
// Top level of the heartbeat liveness table: controller, datapath and port glue.
//
//   channel | direction | handshake                     | payload
//   --------+-----------+-------------------------------+----------------------------------
//   input   | in        | i_in_valid / o_in_stall       | opcode, node_id, sequence_req, now
//   result  | out       | o_out_valid / i_out_stall     | kind .. last (one port per field)
//   config  | in        | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// One item at a time. Add, remove, receive and query search the table entry by entry,
// as it sits in a memory with one write port and a registered read; remove then moves
// each later entry down by one. A tick skips never-seen entries and ages each seen
// entry with the 8-step serial divider.
// Reset (i_rst_n low, synchronous) empties the table and restores register defaults.
// A stalled result holds the controller in its emit state; o_in_stall is high
// from the transfer of an item until its last result is in the output register.
`default_nettype none
module heartbeat_liveness_table import hlt_pkg::*; #(
    parameter int MAX_NEIGHBORS = 16,
    parameter int TIME_WIDTH    = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_node_id,
    input  logic [7:0]  i_sequence_req,
    input  logic [47:0] i_now,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_status,
    output logic [7:0]  o_event_id,
    output logic [1:0]  o_health,
    output logic [7:0]  o_seq_out,
    output logic [7:0]  o_missed,
    output logic [47:0] o_time_since,
    output logic [47:0] o_latency_avg,
    output logic [4:0]  o_count,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;
    logic  in_accept;

    // Handshakes
    assign o_in_stall  = !cmd.in_ready;
    assign in_accept   = i_in_valid && cmd.in_ready;
    assign o_cfg_ready = 1'b1;

    hlt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (in_accept),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    hlt_dp #(
        .MAX_NEIGHBORS (MAX_NEIGHBORS),
        .TIME_WIDTH    (TIME_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_accept    (in_accept),
        .i_opcode       (i_opcode),
        .i_node_id      (i_node_id),
        .i_sequence_req (i_sequence_req),
        .i_now          (i_now),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_kind         (o_kind),
        .o_status       (o_status),
        .o_event_id     (o_event_id),
        .o_health       (o_health),
        .o_seq_out      (o_seq_out),
        .o_missed       (o_missed),
        .o_time_since   (o_time_since),
        .o_latency_avg  (o_latency_avg),
        .o_count        (o_count),
        .o_last         (o_last)
    );

endmodule
`default_nettype wire

[hdl/hlt_dp.sv]
// Datapath: neighbor table memory, registers, serial divider and output register.
`default_nettype none
module hlt_dp import hlt_pkg::*; #(
    parameter int MAX_NEIGHBORS = 16,
    parameter int TIME_WIDTH    = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_accept,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_node_id,
    input  logic [7:0]  i_sequence_req,
    input  logic [47:0] i_now,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_status,
    output logic [7:0]  o_event_id,
    output logic [1:0]  o_health,
    output logic [7:0]  o_seq_out,
    output logic [7:0]  o_missed,
    output logic [47:0] o_time_since,
    output logic [47:0] o_latency_avg,
    output logic [4:0]  o_count,
    output logic        o_last
);

    localparam int TW   = TIME_WIDTH;
    localparam int AW   = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int CNTW = $clog2(MAX_NEIGHBORS + 1);
    localparam int DW   = 40;
    localparam int CW   = (TW > DW) ? TW : DW;

    typedef struct packed {
        logic [7:0]    id;
        logic [1:0]    health;
        logic [TW-1:0] seen_at;
        logic [7:0]    missed;
        logic [7:0]    last_seq;
        logic [TW-1:0] latency;
    } t_entry;

    t_entry          r_mem [MAX_NEIGHBORS];
    t_entry          r_rd;
    logic [31:0]     r_period;
    logic [7:0]      r_timeout;
    logic            r_auto;
    logic            r_track;
    logic [7:0]      r_own_id;
    logic [2:0]      r_op;
    logic [7:0]      r_id;
    logic [7:0]      r_seq;
    logic [TW-1:0]   r_now;
    logic [CNTW-1:0] r_count;
    logic [CNTW-1:0] r_idx;
    logic [CNTW-1:0] r_changes;
    logic [7:0]      r_send_seq;
    logic [TW-1:0]   r_last_send;
    logic            r_div_busy;
    logic [2:0]      r_div_k;
    logic [DW-1:0]   r_rem;
    logic [7:0]      r_q;
    logic [7:0]      r_evt_id;
    logic [1:0]      r_evt_h;
    logic            r_out_valid;

    logic [31:0]     per_eff;
    logic [TW-1:0]   diff_rd;
    logic [CNTW:0]   idx_nxt;
    logic [7:0]      miss_new;
    logic [1:0]      health_new;
    logic [TW-1:0]   lat_d;
    logic [TW-1:0]   lat_new;
    logic [DW-1:0]   div_sub;
    logic            div_ge;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    logic            wr_en;
    t_entry          wr_data;

    // Common arithmetic
    assign per_eff = (r_period == 32'd0) ? 32'd1 : r_period;
    assign diff_rd = r_now - r_rd.seen_at;
    assign idx_nxt = (CNTW + 1)'(r_idx) + (CNTW + 1)'(1);

    // Tick aging of the entry held in the read register
    assign miss_new = (r_q > r_rd.missed) ? r_q : r_rd.missed;
    always_comb begin
        if (miss_new == 8'd0) begin
            health_new = HEALTH_ALIVE;
        end else if (miss_new < r_timeout) begin
            health_new = HEALTH_SUSPECT;
        end else begin
            health_new = HEALTH_DEAD;
        end
    end

    // Latency moving average: seven eighths of the old average plus one eighth of the round trip, rounded down
    always_comb begin
        if (diff_rd >= r_rd.latency) begin
            lat_d   = diff_rd - r_rd.latency;
            lat_new = r_rd.latency + (lat_d >> 3);
        end else begin
            lat_d   = r_rd.latency - diff_rd;
            lat_new = r_rd.latency - ((lat_d >> 3) + TW'(|lat_d[2:0]));
        end
    end

    // Status toward the controller
    always_comb begin
        o_stat.op           = r_op;
        o_stat.op_bad       = r_op > OP_QUERY;
        o_stat.id_invalid   = r_id == INVALID_ID;
        o_stat.idx_lt_cnt   = r_idx < r_count;
        o_stat.nxt_lt_cnt   = idx_nxt < (CNTW + 1)'(r_count);
        o_stat.id_match     = r_rd.id == r_id;
        o_stat.full         = r_count == CNTW'(MAX_NEIGHBORS);
        o_stat.health_zero  = r_rd.health == HEALTH_UNKNOWN;
        o_stat.health_alive = r_rd.health == HEALTH_ALIVE;
        o_stat.div_busy     = r_div_busy;
        o_stat.tick_changed = health_new != r_rd.health;
        o_stat.send_due     = r_auto && ((r_now - r_last_send) >= TW'(per_eff));
        o_stat.out_free     = !r_out_valid || !i_out_stall;
    end

    // Table addresses and write data
    assign rd_addr = i_cmd.rd_next ? idx_nxt[AW-1:0] : r_idx[AW-1:0];
    assign wr_addr = i_cmd.wr_add ? r_count[AW-1:0] : r_idx[AW-1:0];
    assign wr_en   = i_cmd.wr_add | i_cmd.wr_shift | i_cmd.wr_recv | i_cmd.wr_tick;

    always_comb begin
        wr_data = r_rd;
        if (i_cmd.wr_add) begin
            wr_data    = '0;
            wr_data.id = r_id;
        end else if (i_cmd.wr_recv) begin
            wr_data.health   = HEALTH_ALIVE;
            wr_data.seen_at  = r_now;
            wr_data.last_seq = r_seq;
            wr_data.missed   = 8'd0;
            if (r_track && (r_rd.seen_at != '0)) begin
                wr_data.latency = lat_new;
            end
        end else if (i_cmd.wr_tick) begin
            wr_data.missed = miss_new;
            wr_data.health = health_new;
        end
    end

    // Table memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= 32'd10000;
            r_timeout <= 8'd3;
            r_auto    <= 1'b1;
            r_track   <= 1'b0;
            r_own_id  <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PERIOD:  r_period  <= i_cfg_data;
                CFG_TIMEOUT: r_timeout <= i_cfg_data[7:0];
                CFG_AUTO:    r_auto    <= i_cfg_data[0];
                CFG_TRACK:   r_track   <= i_cfg_data[0];
                CFG_OWN_ID:  r_own_id  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Input item capture
    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            r_op  <= i_opcode;
            r_id  <= i_node_id;
            r_seq <= i_sequence_req;
            r_now <= TW'(i_now);
        end
    end

    // Walk index, entry count, change count and send state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_count     <= '0;
            r_changes   <= '0;
            r_send_seq  <= 8'd0;
            r_last_send <= '0;
        end else begin
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CNTW'(1);
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CNTW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CNTW'(1);
            end
            if (i_cmd.chg_clr) begin
                r_changes <= '0;
            end else if (i_cmd.chg_inc) begin
                r_changes <= r_changes + CNTW'(1);
            end
            if (i_cmd.send_upd) begin
                r_send_seq  <= r_send_seq + 8'd1;
                r_last_send <= r_now;
            end
        end
    end

    // Event record captured when a receive or a tick rewrites an entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_recv) begin
            r_evt_id <= r_rd.id;
            r_evt_h  <= HEALTH_ALIVE;
        end else if (i_cmd.wr_tick) begin
            r_evt_id <= r_rd.id;
            r_evt_h  <= health_new;
        end
    end

    // Missed-period divider: saturation test, then one quotient bit a cycle
    assign div_sub = DW'(per_eff) << r_div_k;
    assign div_ge  = r_rem >= div_sub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
        end else if (i_cmd.div_start) begin
            if (CW'(diff_rd) >= (CW'(per_eff) << 8)) begin
                r_q        <= 8'd255;
                r_div_busy <= 1'b0;
            end else begin
                r_rem      <= DW'(diff_rd);
                r_q        <= 8'd0;
                r_div_k    <= 3'd7;
                r_div_busy <= 1'b1;
            end
        end else if (r_div_busy) begin
            if (div_ge) begin
                r_rem        <= r_rem - div_sub;
                r_q[r_div_k] <= 1'b1;
            end
            if (r_div_k == 3'd0) begin
                r_div_busy <= 1'b0;
            end
            r_div_k <= r_div_k - 3'd1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_kind        <= KIND_DONE;
            o_status      <= ST_OK;
            o_event_id    <= 8'd0;
            o_health      <= HEALTH_UNKNOWN;
            o_seq_out     <= 8'd0;
            o_missed      <= 8'd0;
            o_time_since  <= 48'd0;
            o_latency_avg <= 48'd0;
            o_count       <= 5'd0;
            o_last        <= 1'b1;
            case (i_cmd.res)
                RES_DONE: begin
                    o_status   <= i_cmd.status;
                    o_event_id <= r_id;
                    if (i_cmd.since_ones) begin
                        o_time_since <= '1;
                    end
                end
                RES_QUERY: begin
                    o_event_id    <= r_id;
                    o_health      <= r_rd.health;
                    o_seq_out     <= r_rd.last_seq;
                    o_missed      <= r_rd.missed;
                    o_time_since  <= (r_rd.seen_at == '0) ? '1 : 48'(diff_rd);
                    o_latency_avg <= 48'(r_rd.latency);
                end
                RES_EVENT: begin
                    o_kind     <= KIND_EVENT;
                    o_event_id <= r_evt_id;
                    o_health   <= r_evt_h;
                    o_last     <= 1'b0;
                end
                RES_SEND: begin
                    o_kind     <= KIND_SEND;
                    o_event_id <= r_own_id;
                    o_seq_out  <= r_send_seq;
                    o_count    <= 5'(r_count);
                    o_last     <= 1'b0;
                end
                RES_TICK: begin
                    o_count <= 5'(r_changes);
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

[hdl/hlt_ctrl.sv]
// Controller: sequences table search, shift, tick walk and result emission.
`default_nettype none
module hlt_ctrl import hlt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_accept,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [15:0] {
        S_IDLE      = 16'h0001,
        S_DECODE    = 16'h0002,
        S_SRCH_RD   = 16'h0004,
        S_SRCH_CMP  = 16'h0008,
        S_ACT       = 16'h0010,
        S_SHIFT_RD  = 16'h0020,
        S_SHIFT_WR  = 16'h0040,
        S_RECV_EVT  = 16'h0080,
        S_TICK_RD   = 16'h0100,
        S_TICK_CHK  = 16'h0200,
        S_TICK_DIV  = 16'h0400,
        S_TICK_UPD  = 16'h0800,
        S_TICK_EVT  = 16'h1000,
        S_SEND      = 16'h2000,
        S_FINISH    = 16'h4000,
        S_SPARE     = 16'h8000
    } t_state;

    t_state     r_state, n_state;
    t_res       r_fin_res, n_fin_res;
    logic [2:0] r_fin_st, n_fin_st;
    logic       r_fin_ones, n_fin_ones;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fin_res  <= RES_DONE;
            r_fin_st   <= ST_OK;
            r_fin_ones <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fin_res  <= n_fin_res;
            r_fin_st   <= n_fin_st;
            r_fin_ones <= n_fin_ones;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_fin_res  = r_fin_res;
        n_fin_st   = r_fin_st;
        n_fin_ones = r_fin_ones;
        o_cmd      = '0;
        o_cmd.res  = RES_DONE;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_accept) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.idx_clr = 1'b1;
                o_cmd.chg_clr = 1'b1;
                n_fin_res     = RES_DONE;
                n_fin_st      = ST_INVALID;
                n_fin_ones    = 1'b0;
                if (i_stat.op == OP_TICK) begin
                    n_state = S_TICK_RD;
                end else if (i_stat.op_bad) begin
                    n_state = S_FINISH;
                end else if (i_stat.id_invalid) begin
                    n_fin_ones = i_stat.op == OP_QUERY;
                    n_state    = S_FINISH;
                end else begin
                    n_state = S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                if (i_stat.idx_lt_cnt) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_SRCH_CMP;
                end else begin
                    // id not in the table
                    n_state  = S_FINISH;
                    n_fin_st = ST_OK;
                    case (i_stat.op)
                        OP_ADD: begin
                            if (i_stat.full) begin
                                n_fin_st = ST_FULL;
                            end else begin
                                o_cmd.wr_add  = 1'b1;
                                o_cmd.cnt_inc = 1'b1;
                            end
                        end
                        OP_REMOVE: n_fin_st = ST_NOTFOUND;
                        OP_QUERY: begin
                            n_fin_st   = ST_NOTFOUND;
                            n_fin_ones = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_SRCH_CMP: begin
                if (i_stat.id_match) begin
                    n_state = S_ACT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SRCH_RD;
                end
            end
            S_ACT: begin
                // id found at the walk index, entry in the read register
                n_fin_st = ST_OK;
                n_state  = S_FINISH;
                case (i_stat.op)
                    OP_ADD: n_fin_st = ST_EXISTS;
                    OP_REMOVE: n_state = S_SHIFT_RD;
                    OP_RECV: begin
                        o_cmd.wr_recv = 1'b1;
                        if (!i_stat.health_alive) begin
                            n_state = S_RECV_EVT;
                        end
                    end
                    OP_QUERY: n_fin_res = RES_QUERY;
                    default: ;
                endcase
            end
            S_SHIFT_RD: begin
                if (i_stat.nxt_lt_cnt) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_next = 1'b1;
                    n_state       = S_SHIFT_WR;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_FINISH;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state        = S_SHIFT_RD;
            end
            S_RECV_EVT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.res      = RES_EVENT;
                    n_state        = S_FINISH;
                end
            end
            S_TICK_RD: begin
                if (i_stat.idx_lt_cnt) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_TICK_CHK;
                end else begin
                    n_state = S_SEND;
                end
            end
            S_TICK_CHK: begin
                // never-seen entries are skipped
                if (i_stat.health_zero) begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_TICK_RD;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_TICK_DIV;
                end
            end
            S_TICK_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = S_TICK_UPD;
                end
            end
            S_TICK_UPD: begin
                o_cmd.wr_tick = 1'b1;
                if (i_stat.tick_changed) begin
                    o_cmd.chg_inc = 1'b1;
                    n_state       = S_TICK_EVT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_TICK_RD;
                end
            end
            S_TICK_EVT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.res      = RES_EVENT;
                    o_cmd.idx_inc  = 1'b1;
                    n_state        = S_TICK_RD;
                end
            end
            S_SEND: begin
                n_fin_res = RES_TICK;
                if (!i_stat.send_due) begin
                    n_state = S_FINISH;
                end else if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.res      = RES_SEND;
                    o_cmd.send_upd = 1'b1;
                    n_state        = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.res        = r_fin_res;
                    o_cmd.status     = r_fin_st;
                    o_cmd.since_ones = r_fin_ones;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[hdl/hlt_checker.sv]
// Port-level checks for the heartbeat liveness table and their bind.
`default_nettype none
module hlt_checker import hlt_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_kind,
    input logic [2:0] o_status,
    input logic [4:0] o_count,
    input logic       o_last
);

    // one item in flight: a transfer closes the input side
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an item was in work");

    // only completion records end an item
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_kind == KIND_DONE)))
        else $error("last flag does not match result kind");

    // events and send records carry status ok
    a_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind != KIND_DONE)) |-> (o_status == ST_OK))
        else $error("non-completion result with error status");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_kind) && $stable(o_count) && $stable(o_last)))
        else $error("stalled result changed");

endmodule

bind heartbeat_liveness_table hlt_checker u_hlt_checker (.*);
`default_nettype wire
